// ===== design/v4vu_pkg.sv =====
// Shared types and constants for the four-component vector unit.
package v4vu_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned SQRT_STAGES   = 33;

    localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        MODE_LENGTH = 2'd0,
        MODE_NORM   = 2'd1,
        MODE_DOT    = 2'd2,
        MODE_CROSS  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t            mode;
        logic [3:0][31:0] a;
        logic [3:0][31:0] b;
    } in_word_t;

    typedef struct packed {
        mode_t            mode;
        logic [3:0][31:0] a;
        logic [31:0]      bw;
    } side_t;

    typedef struct packed {
        mode_t            mode;
        logic [3:0][31:0] a;
        logic [3:0][31:0] res;
        logic [31:0]      scalar;
        logic             sat;
        logic             zero;
    } tail_t;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } clip_t;

    function automatic clip_t clip32(input logic signed [65:0] v);
        clip_t c;
        if ((&v[65:31]) || !(|v[65:31]))
        begin
            c.value = v[31:0];
            c.sat   = 1'b0;
        end
        else
        begin
            c.value = v[65] ? S32_MIN : S32_MAX;
            c.sat   = 1'b1;
        end
        return c;
    endfunction

endpackage

// ===== design/vec4_vector_unit_top.sv =====
// Four-component fixed-point vector unit: length, normalize, dot and cross.
//
// Fully pipelined: one word is taken every cycle (busy stays low) and its
// result is strobed on done after passing the input, product, sum and
// clip registers, the 33-stage square root, the FRAC_BITS + 1 stage
// divider lanes and the output register; every mode runs through the
// same depth, so results leave in order. The receiver cannot stall the
// output.
module vec4_vector_unit_top #(
    parameter int unsigned FRAC_BITS = v4vu_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [31:0] a_x,
    input  logic [31:0] a_y,
    input  logic [31:0] a_z,
    input  logic [31:0] a_w,
    input  logic [31:0] b_x,
    input  logic [31:0] b_y,
    input  logic [31:0] b_z,
    input  logic [31:0] b_w,
    output logic        done,
    output logic [31:0] res_x,
    output logic [31:0] res_y,
    output logic [31:0] res_z,
    output logic [31:0] res_w,
    output logic [31:0] scalar_out,
    output logic        zero_length,
    output logic        saturated
);
    import v4vu_pkg::*;

    localparam int unsigned DS   = FRAC_BITS + 1;
    localparam int unsigned TAIL = SQRT_STAGES + DS;

    // stage 0: input word
    logic     v0_reg;
    in_word_t w0_reg;

    // stage 1: products
    logic               v1_reg;
    side_t              s1_reg;
    logic signed [63:0] p1_reg [6];
    logic signed [31:0] ml [6];
    logic signed [31:0] mr [6];
    logic signed [63:0] p1_next [6];

    // stage 2: partial sums
    logic               v2_reg;
    side_t              s2_reg;
    logic signed [65:0] s2_sum_reg [3];
    logic signed [65:0] e [6];
    logic signed [65:0] s2_next [3];

    // stage 3: final sums, shift and clip
    logic               v3_reg;
    tail_t              t3_reg;
    logic [64:0]        rad3_reg;
    tail_t              t3_next;
    logic signed [65:0] total;
    clip_t              c_dot;
    clip_t              c_x;
    clip_t              c_y;
    clip_t              c_z;

    // tail through sqrt and divide
    logic        vl_reg [TAIL];
    tail_t       dl_reg [TAIL];
    logic [32:0] root;
    logic [32:0] rd_reg [DS];
    logic [FRAC_BITS:0] q [4];
    logic [3:0][31:0]   m_abs;

    logic        done_reg;
    tail_t       out_reg;
    tail_t       out_next;
    tail_t       dl_end;
    logic [32:0] root_end;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            w0_reg.mode <= mode_t'(mode);
            w0_reg.a    <= {a_w, a_z, a_y, a_x};
            w0_reg.b    <= {b_w, b_z, b_y, b_x};
        end
    end

    // multiplier operand select
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            ml[i] = '0;
            mr[i] = '0;
        end
        case (w0_reg.mode)
            MODE_LENGTH, MODE_NORM:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    ml[i] = w0_reg.a[i];
                    mr[i] = w0_reg.a[i];
                end
            end
            MODE_DOT:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    ml[i] = w0_reg.a[i];
                    mr[i] = w0_reg.b[i];
                end
            end
            MODE_CROSS:
            begin
                ml[0] = w0_reg.a[1]; mr[0] = w0_reg.b[2];
                ml[1] = w0_reg.a[2]; mr[1] = w0_reg.b[1];
                ml[2] = w0_reg.a[2]; mr[2] = w0_reg.b[0];
                ml[3] = w0_reg.a[0]; mr[3] = w0_reg.b[2];
                ml[4] = w0_reg.a[0]; mr[4] = w0_reg.b[1];
                ml[5] = w0_reg.a[1]; mr[5] = w0_reg.b[0];
            end
            default:
            begin
                ml[0] = '0;
            end
        endcase
        for (int i = 0; i < 6; i++)
        begin
            p1_next[i] = ml[i] * mr[i];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg.mode <= w0_reg.mode;
        s1_reg.a    <= w0_reg.a;
        s1_reg.bw   <= w0_reg.b[3];
        for (int i = 0; i < 6; i++)
        begin
            p1_reg[i] <= p1_next[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            e[i] = p1_reg[i];
        end
        if (s1_reg.mode == MODE_CROSS)
        begin
            s2_next[0] = e[0] - e[1];
            s2_next[1] = e[2] - e[3];
            s2_next[2] = e[4] - e[5];
        end
        else
        begin
            s2_next[0] = e[0] + e[1];
            s2_next[1] = e[2] + e[3];
            s2_next[2] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg <= s1_reg;
        for (int i = 0; i < 3; i++)
        begin
            s2_sum_reg[i] <= s2_next[i];
        end
    end

    always_comb
    begin
        total = s2_sum_reg[0] + s2_sum_reg[1];
        c_dot = clip32(total >>> FRAC_BITS);
        c_x   = clip32(s2_sum_reg[0] >>> FRAC_BITS);
        c_y   = clip32(s2_sum_reg[1] >>> FRAC_BITS);
        c_z   = clip32(s2_sum_reg[2] >>> FRAC_BITS);

        t3_next.mode   = s2_reg.mode;
        t3_next.a      = s2_reg.a;
        t3_next.res    = '0;
        t3_next.scalar = '0;
        t3_next.sat    = 1'b0;
        t3_next.zero   = (s2_reg.a == '0);
        case (s2_reg.mode)
            MODE_DOT:
            begin
                t3_next.scalar = c_dot.value;
                t3_next.sat    = c_dot.sat;
            end
            MODE_CROSS:
            begin
                t3_next.res = {s2_reg.bw, c_z.value, c_y.value, c_x.value};
                t3_next.sat = c_x.sat | c_y.sat | c_z.sat;
            end
            default:
            begin
                t3_next.sat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        t3_reg   <= t3_next;
        rad3_reg <= total[64:0];
    end

    v4vu_sqrt u_sqrt (
        .clk  (clk),
        .rad  (rad3_reg),
        .root (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TAIL; k++)
            begin
                vl_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            vl_reg[0] <= v3_reg;
            for (int k = 1; k < TAIL; k++)
            begin
                vl_reg[k] <= vl_reg[k-1];
            end
            done_reg <= vl_reg[TAIL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg[0] <= t3_reg;
        for (int k = 1; k < TAIL; k++)
        begin
            dl_reg[k] <= dl_reg[k-1];
        end
        rd_reg[0] <= root;
        for (int k = 1; k < DS; k++)
        begin
            rd_reg[k] <= rd_reg[k-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            m_abs[i] = dl_reg[SQRT_STAGES-1].a[i][31] ?
                       32'(-dl_reg[SQRT_STAGES-1].a[i]) : dl_reg[SQRT_STAGES-1].a[i];
        end
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        v4vu_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk (clk),
            .m   (m_abs[i]),
            .d   (root),
            .q   (q[i])
        );
    end

    assign dl_end   = dl_reg[TAIL-1];
    assign root_end = rd_reg[DS-1];

    always_comb
    begin
        out_next = dl_end;
        case (dl_end.mode)
            MODE_LENGTH:
            begin
                if (root_end[32] || root_end[31])
                begin
                    out_next.scalar = S32_MAX;
                    out_next.sat    = 1'b1;
                end
                else
                begin
                    out_next.scalar = root_end[31:0];
                    out_next.sat    = 1'b0;
                end
                out_next.zero = 1'b0;
            end
            MODE_NORM:
            begin
                if (dl_end.zero)
                begin
                    out_next.res = dl_end.a;
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        out_next.res[i] = dl_end.a[i][31] ? 32'(-32'(q[i])) : 32'(q[i]);
                    end
                end
                out_next.sat = 1'b0;
            end
            default:
            begin
                out_next.zero = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done        = done_reg;
    assign res_x       = out_reg.res[0];
    assign res_y       = out_reg.res[1];
    assign res_z       = out_reg.res[2];
    assign res_w       = out_reg.res[3];
    assign scalar_out  = out_reg.scalar;
    assign zero_length = out_reg.zero;
    assign saturated   = out_reg.sat;

endmodule

// ===== design/v4vu_sqrt.sv =====
// Pipelined restoring integer square root, one root bit per stage.
module v4vu_sqrt (
    input  logic        clk,
    input  logic [64:0] rad,
    output logic [32:0] root
);
    import v4vu_pkg::*;

    logic [65:0] rad_reg  [SQRT_STAGES];
    logic [34:0] rem_reg  [SQRT_STAGES];
    logic [32:0] root_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_stage
        logic [65:0] rad_cur;
        logic [34:0] rem_cur;
        logic [32:0] root_cur;
        logic [36:0] t;
        logic [36:0] trial;
        logic        ge;
        logic [65:0] rad_next;
        logic [34:0] rem_next;
        logic [32:0] root_next;

        if (k == 0)
        begin : g_first
            assign rad_cur  = {1'b0, rad};
            assign rem_cur  = '0;
            assign root_cur = '0;
        end
        else
        begin : g_rest
            assign rad_cur  = rad_reg[k-1];
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
        end

        always_comb
        begin
            t         = {rem_cur, rad_cur[65:64]};
            trial     = {2'b00, root_cur, 2'b01};
            ge        = (t >= trial);
            rem_next  = ge ? 35'(t - trial) : t[34:0];
            root_next = {root_cur[31:0], ge};
            rad_next  = {rad_cur[63:0], 2'b00};
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k]  <= rad_next;
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule

// ===== design/v4vu_div.sv =====
// Pipelined restoring divider for one normalize lane, one quotient bit per stage.
module v4vu_div #(
    parameter int unsigned FRAC_BITS = v4vu_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic [31:0]        m,
    input  logic [32:0]        d,
    output logic [FRAC_BITS:0] q
);
    localparam int unsigned DS = FRAC_BITS + 1;

    logic [32:0]        r_reg    [DS];
    logic [32:0]        d_reg    [DS];
    logic [FRAC_BITS:0] bits_reg [DS];
    logic [FRAC_BITS:0] q_reg    [DS];

    for (genvar k = 0; k < DS; k++)
    begin : g_stage
        logic [32:0]        r_cur;
        logic [32:0]        d_cur;
        logic [FRAC_BITS:0] bits_cur;
        logic [FRAC_BITS:0] q_cur;
        logic [33:0]        t;
        logic               ge;
        logic [32:0]        r_next;
        logic [FRAC_BITS:0] bits_next;
        logic [FRAC_BITS:0] q_next;

        if (k == 0)
        begin : g_first
            assign r_cur    = {2'b00, m[31:1]};
            assign d_cur    = d;
            assign bits_cur = {m[0], {FRAC_BITS{1'b0}}};
            assign q_cur    = '0;
        end
        else
        begin : g_rest
            assign r_cur    = r_reg[k-1];
            assign d_cur    = d_reg[k-1];
            assign bits_cur = bits_reg[k-1];
            assign q_cur    = q_reg[k-1];
        end

        always_comb
        begin
            t         = {r_cur, bits_cur[FRAC_BITS]};
            ge        = (t >= {1'b0, d_cur});
            r_next    = ge ? 33'(t - {1'b0, d_cur}) : t[32:0];
            bits_next = {bits_cur[FRAC_BITS-1:0], 1'b0};
            q_next    = {q_cur[FRAC_BITS-1:0], ge};
        end

        always_ff @(posedge clk)
        begin
            r_reg[k]    <= r_next;
            d_reg[k]    <= d_cur;
            bits_reg[k] <= bits_next;
            q_reg[k]    <= q_next;
        end
    end

    assign q = q_reg[DS-1];

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the four-component fixed-point vector unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import v4vu_pkg::*;

    localparam int FB        = FRAC_BITS_DEF;
    localparam int LATENCY   = 38 + FB;
    localparam int MAX_CYCLE = 400000;

    typedef struct {
        logic [31:0] rx, ry, rz, rw, sc;
        logic        zl, sat;
    } vec_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  mode = '0;
    logic [31:0] a_x = '0, a_y = '0, a_z = '0, a_w = '0;
    logic [31:0] b_x = '0, b_y = '0, b_z = '0, b_w = '0;
    logic        busy, done, zero_length, saturated;
    logic [31:0] res_x, res_y, res_z, res_w, scalar_out;

    vec_result_t pending_q[$];
    int          errors = 0;
    longint      cycles = 0;
    int          burst_left = 0;

    vec4_vector_unit_top u_top (.*);

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic logic signed [65:0] floor_sh(input logic signed [65:0] v);
        return v >>> FB;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [65:0] v, inout logic s);
        if (v > 66'sd2147483647)
        begin
            s = 1'b1;
            return S32_MAX;
        end
        if (v < -66'sd2147483648)
        begin
            s = 1'b1;
            return S32_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic [32:0] root_floor(input logic [65:0] v);
        logic [65:0] lo, hi, mid;
        lo = 0;
        hi = 66'h1_0000_0001;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid;
        end
        return lo[32:0];
    endfunction

    function automatic vec_result_t compute_vec(input logic [1:0] m,
                                                input logic [31:0] a[4],
                                                input logic [31:0] b[4]);
        vec_result_t r;
        logic signed [65:0] sa[4], sb[4], acc, cx, cy, cz, mag, q;
        logic [65:0] sumsq;
        logic [32:0] len;
        logic s;
        s = 1'b0;
        r = '{default: '0};
        for (int i = 0; i < 4; i++)
        begin
            sa[i] = $signed(a[i]);
            sb[i] = $signed(b[i]);
        end
        sumsq = 0;
        for (int i = 0; i < 4; i++)
            sumsq += sa[i] * sa[i];
        len = root_floor(sumsq);
        case (mode_t'(m))
            MODE_LENGTH:
                r.sc = sat32($signed({33'd0, len}), s);
            MODE_NORM:
                if (sumsq == 0)
                begin
                    r.zl = 1'b1;
                    {r.rx, r.ry, r.rz, r.rw} = {a[0], a[1], a[2], a[3]};
                end
                else
                begin
                    logic [31:0] o[4];
                    for (int i = 0; i < 4; i++)
                    begin
                        mag = (sa[i] < 0 ? -sa[i] : sa[i]) <<< FB;
                        q = mag / $signed({33'd0, len});
                        o[i] = sat32(sa[i] < 0 ? -q : q, s);
                    end
                    {r.rx, r.ry, r.rz, r.rw} = {o[0], o[1], o[2], o[3]};
                end
            MODE_DOT:
            begin
                acc = 0;
                for (int i = 0; i < 4; i++)
                    acc += sa[i] * sb[i];
                r.sc = sat32(floor_sh(acc), s);
            end
            default:
            begin
                cx = sa[1] * sb[2] - sa[2] * sb[1];
                cy = sa[2] * sb[0] - sa[0] * sb[2];
                cz = sa[0] * sb[1] - sa[1] * sb[0];
                r.rx = sat32(floor_sh(cx), s);
                r.ry = sat32(floor_sh(cy), s);
                r.rz = sat32(floor_sh(cz), s);
                r.rw = b[3];
            end
        endcase
        r.sat = s;
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            vec_result_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t unexpected result word", $realtime);
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                if ({res_x, res_y, res_z, res_w, scalar_out, zero_length, saturated} !==
                    {e.rx, e.ry, e.rz, e.rw, e.sc, e.zl, e.sat})
                begin
                    $display("%0t mismatch exp %h %h %h %h %h zl=%b sat=%b", $realtime,
                             e.rx, e.ry, e.rz, e.rw, e.sc, e.zl, e.sat);
                    $display("%0t          got %h %h %h %h %h zl=%b sat=%b", $realtime,
                             res_x, res_y, res_z, res_w, scalar_out, zero_length,
                             saturated);
                    errors++;
                end
            end
        end
    end

    task automatic send_word(input logic [1:0] m, input logic [31:0] a[4],
                             input logic [31:0] b[4]);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 2) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        burst_left--;
        mode <= m;
        {a_x, a_y, a_z, a_w} <= {a[0], a[1], a[2], a[3]};
        {b_x, b_y, b_z, b_w} <= {b[0], b[1], b[2], b[3]};
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_q.push_back(compute_vec(m, a, b));
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            3: return '0;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] ext[6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                                32'h0001_0000, 32'hffff_0000};
        logic [31:0] a[4], b[4];
        for (int m = 0; m < 4; m++)
        begin
            a = '{0, 0, 0, 0};
            b = '{0, 0, 0, 0};
            send_word(2'(m), a, b);
            for (int k = 0; k < 4; k++)
            begin
                a = '{ext[k], ext[(k + 1) % 6], ext[(k + 2) % 6], ext[k]};
                b = '{ext[(k + 3) % 6], ext[k], ext[(k + 4) % 6], ext[(k + 5) % 6]};
                send_word(2'(m), a, b);
            end
        end
        a = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_word(MODE_LENGTH, a, a);
        send_word(MODE_NORM, a, a);
        a = '{32'h0, 32'h0, 32'h0, 32'h1};
        send_word(MODE_NORM, a, a);
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_random(input int count);
        logic [31:0] a[4], b[4];
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                a[i] = rand_comp();
                b[i] = rand_comp();
            end
            send_word(2'($urandom_range(0, 3)), a, b);
            if (n == count / 2)
                wait_drain();
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        wait_drain();
        test_random(700);
        wait_drain();
        repeat (LATENCY + 10) @(negedge clk);
        if (errors == 0 && pending_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
